/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock, off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: assertion failed");

// Implication form: whenever trig holds, cons must hold in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, trig, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
      else $error("%m: implication failed");

`endif

/* hw/rtl/slcfb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package slcfb_pkg;

   typedef logic [7:0]  byte_type;
   typedef logic [15:0] crc_type;

   localparam crc_type  CRC_INIT     = 16'hFFFF;
   localparam crc_type  CRC_POLY     = 16'h1021;
   localparam byte_type SYNC_FIRST   = 8'hAA;
   localparam byte_type SYNC_SECOND  = 8'h55;
   localparam byte_type RESET_LENGTH = 8'd24;

   // Position of a beat inside the results of one payload byte.
   typedef enum logic [2:0] {
      SLOT_SYNC1  = 3'd0,
      SLOT_SYNC2  = 3'd1,
      SLOT_LEN    = 3'd2,
      SLOT_DATA   = 3'd3,
      SLOT_CRC_HI = 3'd4,
      SLOT_CRC_LO = 3'd5
   } slot_type;

   // Everything needed to emit the beats of one accepted payload byte.
   typedef struct packed {
      byte_type data;
      byte_type len;
      crc_type  crc;
      logic     tail;
   } item_type;

endpackage

`default_nettype wire

/* hw/rtl/slcfb_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface slcfb_req_if;
   logic                valid;
   logic                ready;
   slcfb_pkg::byte_type payload_byte;

   modport source (output valid, output payload_byte, input ready);
   modport sink   (input valid, input payload_byte, output ready);
endinterface

`default_nettype wire

/* hw/rtl/slcfb_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface slcfb_rsp_if;
   logic                valid;
   logic                ready;
   slcfb_pkg::byte_type frame_byte;
   logic                frame_end;
   logic                run_last;

   modport source (output valid, output frame_byte, output frame_end, output run_last,
                   input ready);
   modport sink   (input valid, input frame_byte, input frame_end, input run_last,
                   output ready);
endinterface

`default_nettype wire

/* hw/rtl/sync_len_crc16_frame_builder.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Channel   Dir  Handshake      Beat contents
// req       in   valid/ready    payload_byte
// rsp       out  valid/ready    frame_byte, frame_end, run_last
// csr       in   write enable   csr_write_data = payload length (0 means 256)
//
// One payload byte gives 1 to 6 output beats (1 mid-frame, up to 6 for a frame
// of one byte); one beat leaves per cycle while rsp is not stalled. The item
// register and the rsp register form a two-entry path: the next byte is taken
// in the cycle its predecessor's last beat moves into the rsp register.
// The CRC update is done in the accepting cycle, 8 bit steps in one cone.
// Reset is synchronous: CRC 0xFFFF, start of frame, length 24, both stages empty.
// A stall on rsp holds the output beat; the item register then backs up req.

module sync_len_crc16_frame_builder (
   input  wire                      clock,
   input  wire                      reset,
   slcfb_req_if.sink                req,
   slcfb_rsp_if.source              rsp,
   input  wire                      csr_write_enable,
   input  wire slcfb_pkg::byte_type csr_write_data
);

   // CRC16-CCITT, MSB first, one byte.
   function automatic slcfb_pkg::crc_type crc_feed(input slcfb_pkg::crc_type crc_i,
                                                   input slcfb_pkg::byte_type b);
      slcfb_pkg::crc_type c;
      c = crc_i ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ slcfb_pkg::CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

   // Frame state
   slcfb_pkg::crc_type  crc_ff, crc_in;
   slcfb_pkg::byte_type taken_ff, taken_in;
   slcfb_pkg::byte_type len_ff, len_in;

   // Item register
   logic                a_valid_ff, a_valid_in;
   slcfb_pkg::item_type a_item_ff, a_item_in;
   slcfb_pkg::slot_type a_pos_ff, a_pos_in;

   // Output register
   logic                rsp_valid_ff, rsp_valid_in;
   slcfb_pkg::byte_type rsp_byte_ff, rsp_byte_in;
   logic                rsp_end_ff, rsp_end_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                out_load;
   logic                issue;
   logic                a_last;
   slcfb_pkg::slot_type last_slot;
   logic                accept;
   slcfb_pkg::crc_type  crc_next;
   logic [8:0]          taken_now;
   logic [8:0]          limit;
   logic                head;
   logic                tail;
   slcfb_pkg::byte_type slot_byte;

   assign out_load  = !rsp_valid_ff || rsp.ready;
   assign issue     = a_valid_ff && out_load;
   assign last_slot = a_item_ff.tail ? slcfb_pkg::SLOT_CRC_LO : slcfb_pkg::SLOT_DATA;
   assign a_last    = (a_pos_ff == last_slot);
   assign req.ready = !a_valid_ff || (issue && a_last);
   assign accept    = req.valid && req.ready;

   // Frame bookkeeping for the incoming byte.
   assign crc_next  = crc_feed(crc_ff, req.payload_byte);
   assign taken_now = {1'b0, taken_ff} + 9'd1;
   assign limit     = (len_ff == 8'd0) ? 9'd256 : {1'b0, len_ff};
   assign head      = (taken_ff == 8'd0);
   assign tail      = (taken_now >= limit);

   always_comb begin
      crc_in   = crc_ff;
      taken_in = taken_ff;
      len_in   = csr_write_enable ? csr_write_data : len_ff;
      if (accept) begin
         crc_in   = tail ? slcfb_pkg::CRC_INIT : crc_next;
         taken_in = tail ? 8'd0 : taken_now[7:0];
      end
   end

   // Beat selection for the current slot.
   always_comb begin
      unique case (a_pos_ff)
         slcfb_pkg::SLOT_SYNC1:  slot_byte = slcfb_pkg::SYNC_FIRST;
         slcfb_pkg::SLOT_SYNC2:  slot_byte = slcfb_pkg::SYNC_SECOND;
         slcfb_pkg::SLOT_LEN:    slot_byte = a_item_ff.len;
         slcfb_pkg::SLOT_DATA:   slot_byte = a_item_ff.data;
         slcfb_pkg::SLOT_CRC_HI: slot_byte = a_item_ff.crc[15:8];
         slcfb_pkg::SLOT_CRC_LO: slot_byte = a_item_ff.crc[7:0];
         default:                slot_byte = a_item_ff.data;
      endcase
   end

   always_comb begin
      a_valid_in = a_valid_ff;
      a_item_in  = a_item_ff;
      a_pos_in   = a_pos_ff;
      if (accept) begin
         a_valid_in     = 1'b1;
         a_item_in.data = req.payload_byte;
         a_item_in.len  = len_ff;
         a_item_in.crc  = crc_next;
         a_item_in.tail = tail;
         a_pos_in       = head ? slcfb_pkg::SLOT_SYNC1 : slcfb_pkg::SLOT_DATA;
      end else if (issue && a_last) begin
         a_valid_in = 1'b0;
      end else if (issue) begin
         a_pos_in = slcfb_pkg::slot_type'(a_pos_ff + 3'd1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_load) begin
         rsp_valid_in = issue;
         rsp_byte_in  = slot_byte;
         rsp_end_in   = (a_pos_ff == slcfb_pkg::SLOT_CRC_LO);
         rsp_last_in  = a_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= slcfb_pkg::CRC_INIT;
         taken_ff     <= 8'd0;
         len_ff       <= slcfb_pkg::RESET_LENGTH;
         a_valid_ff   <= 1'b0;
         a_pos_ff     <= slcfb_pkg::SLOT_SYNC1;
         rsp_valid_ff <= 1'b0;
      end else begin
         crc_ff       <= crc_in;
         taken_ff     <= taken_in;
         len_ff       <= len_in;
         a_valid_ff   <= a_valid_in;
         a_pos_ff     <= a_pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload, no reset needed.
   always_ff @(posedge clock) begin
      a_item_ff   <= a_item_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_end_ff  <= rsp_end_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.frame_byte = rsp_byte_ff;
   assign rsp.frame_end  = rsp_end_ff;
   assign rsp.run_last   = rsp_last_ff;

   // The slot never walks past the last beat of its byte.
   `ASSERT_IMPLIES(a_pos_in_range, clock, reset, a_valid_ff, a_pos_ff <= last_slot)
   // At the start of a frame the running CRC is back at its seed.
   `ASSERT_IMPLIES(crc_seed_at_start, clock, reset, taken_ff == 8'd0,
                   crc_ff == slcfb_pkg::CRC_INIT)
   // The closing CRC beat is always the final beat of its payload byte.
   `ASSERT_IMPLIES(end_is_last, clock, reset, rsp_valid_ff && rsp_end_ff, rsp_last_ff)

endmodule

`default_nettype wire
